FILE: sv/crc_frame_receiver_assert.svh
// assertion macros shared by the frame receiver modules
// no dependencies; included inside the module bodies that assert
`ifndef CRC_FRAME_RECEIVER_ASSERT_SVH
`define CRC_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define CFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cfr_pkg.sv
// shared types, constants and the crc byte update for the frame receiver
// no dependencies
package cfr_pkg;

    localparam int MAX_PAYLOAD = 256;
    localparam int LEN_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_START_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 2'd2;

    localparam logic [7:0]       START_FLAG_RST = 8'd126;
    localparam logic [7:0]       END_FLAG_RST   = 8'd125;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 9'd256;
    localparam logic [LEN_W-1:0] CAP_LIMIT      = LEN_W'(MAX_PAYLOAD);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NAK = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_END
    } t_phase;

    // one classified byte handed from front to back
    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [7:0]       byte_index;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic [15:0]      rx_crc;
        logic             bad_end;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // crc-16 ccitt, poly 0x1021, one byte msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'b0, x[7:4]};
        return {crc[7:0], 8'b0} ^ {x[3:0], 12'b0} ^ {3'b0, x, 5'b0} ^ {8'b0, x};
    endfunction

endpackage

FILE: sv/cfr_rx_if.sv
// received byte channel of the frame receiver
// no dependencies
interface cfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/cfr_res_if.sv
// result channel of the frame receiver
// no dependencies
interface cfr_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data;
    logic [7:0] byte_index;
    logic [7:0] command;
    logic [8:0] length;
    logic [1:0] status;

    modport source (output valid, output kind, output data, output byte_index,
                    output command, output length, output status, input ready);
    modport sink (input valid, input kind, input data, input byte_index,
                  input command, input length, input status, output ready);
endinterface

FILE: sv/crc_frame_receiver.sv
// a taken payload byte or end byte is written into the op queue and is then popped into the
// output register that drives the result channel; result backpressure can stall the pop
// throughput: one byte per cycle; a 4-entry op queue and one output register decouple the sides
// ready drops only while the op queue is full under result backpressure
// reset: synchronous active low; flags, capacity, phase, crc and queue return at once
// top level: frame parser, op queue and result stage; depends on cfr_pkg and both interfaces
module crc_frame_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cfr_rx_if.sink                         i_rx,
    cfr_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cfr_pkg::*;

    t_op        push_op;
    t_op        head_op;
    t_fifo_stat stat;
    logic       push;
    logic       pop;

    cfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_push     (push),
        .o_op       (push_op)
    );

    cfr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_op),
        .i_pop   (pop),
        .o_rdata (head_op),
        .o_stat  (stat)
    );

    cfr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (head_op),
        .i_stat  (stat),
        .o_pop   (pop),
        .o_res   (o_res)
    );
endmodule

FILE: sv/cfr_fifo.sv
// small op queue between the frame parser and the result stage
// depends on cfr_pkg and crc_frame_receiver_assert.svh
module cfr_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfr_pkg::t_op        i_wdata,
    input  logic                i_pop,
    output cfr_pkg::t_op        o_rdata,
    output cfr_pkg::t_fifo_stat o_stat
);
    import cfr_pkg::*;
    `include "crc_frame_receiver_assert.svh"

    t_op                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW-1:0] n_wptr;
    logic [FIFO_AW-1:0] n_rptr;
    logic [FIFO_AW:0]   n_cnt;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_rdata      = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    `CFR_ASSERT_IMPL(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count over depth")
    `CFR_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, !o_stat.full || i_pop, "push into full queue")
    `CFR_ASSERT_NEXT(a_cnt_grow, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1, "queue count did not grow")
endmodule

FILE: sv/cfr_front.sv
// frame parser: config registers, phase tracking, byte classification
// depends on cfr_pkg and cfr_rx_if
module cfr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cfr_rx_if.sink                            i_rx,
    input  logic                              i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cfr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  cfr_pkg::t_fifo_stat               i_stat,
    output logic                              o_push,
    output cfr_pkg::t_op                      o_op
);
    import cfr_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [7:0]       r_start_flag;
    logic [7:0]       r_end_flag;
    logic [LEN_W-1:0] r_max_len;
    logic [7:0]       r_cmd;
    logic [7:0]       r_len_lo;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_cnt;
    logic [7:0]       r_crc_lo;
    logic [15:0]      r_rx_crc;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] n_cnt;
    logic             take;
    logic [15:0]      len_full;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] cnt_inc;

    assign i_rx.ready = !i_stat.full;
    assign take       = i_rx.valid && !i_stat.full;
    assign len_full   = {i_rx.rx_byte, r_len_lo};
    assign cap        = (r_max_len < CAP_LIMIT) ? r_max_len : CAP_LIMIT;
    assign cnt_inc    = r_cnt + 1'b1;

    always_comb begin
        n_len = (len_full > {{(16-LEN_W){1'b0}}, cap}) ? cap : len_full[LEN_W-1:0];
        n_cnt = (r_phase == PH_PAYLOAD) ? cnt_inc : '0;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (take) begin
            unique case (r_phase)
                PH_HUNT:    n_phase = (i_rx.rx_byte == r_start_flag) ? PH_CMD : PH_HUNT;
                PH_CMD:     n_phase = PH_LEN_LO;
                PH_LEN_LO:  n_phase = PH_LEN_HI;
                PH_LEN_HI:  n_phase = (n_len == '0) ? PH_CRC_LO : PH_PAYLOAD;
                PH_PAYLOAD: n_phase = (cnt_inc >= r_len) ? PH_CRC_LO : PH_PAYLOAD;
                PH_CRC_LO:  n_phase = PH_CRC_HI;
                PH_CRC_HI:  n_phase = PH_END;
                PH_END:     n_phase = PH_HUNT;
                default:    n_phase = PH_HUNT;
            endcase
        end
    end

    // op to the queue
    always_comb begin
        o_push          = 1'b0;
        o_op.kind       = KIND_PAYLOAD;
        o_op.data       = i_rx.rx_byte;
        o_op.byte_index = r_cnt[7:0];
        o_op.command    = r_cmd;
        o_op.length     = r_len;
        o_op.rx_crc     = r_rx_crc;
        o_op.bad_end    = (i_rx.rx_byte != r_end_flag);
        unique case (r_phase)
            PH_PAYLOAD: o_push = take;
            PH_END: begin
                o_push    = take;
                o_op.kind = KIND_SUMMARY;
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_start_flag <= START_FLAG_RST;
            r_end_flag   <= END_FLAG_RST;
            r_max_len    <= MAX_LENGTH_RST;
            r_cmd        <= '0;
            r_len_lo     <= '0;
            r_len        <= '0;
            r_cnt        <= '0;
            r_crc_lo     <= '0;
            r_rx_crc     <= '0;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_FLAG: r_start_flag <= i_cfg_data[7:0];
                    CFG_END_FLAG:   r_end_flag   <= i_cfg_data[7:0];
                    CFG_MAX_LENGTH: r_max_len    <= i_cfg_data[LEN_W-1:0];
                    default:        r_max_len    <= r_max_len;
                endcase
            end
            if (take) begin
                case (r_phase)
                    PH_CMD:     r_cmd    <= i_rx.rx_byte;
                    PH_LEN_LO:  r_len_lo <= i_rx.rx_byte;
                    PH_LEN_HI: begin
                        r_len <= n_len;
                        r_cnt <= n_cnt;
                    end
                    PH_PAYLOAD: r_cnt    <= n_cnt;
                    PH_CRC_LO:  r_crc_lo <= i_rx.rx_byte;
                    PH_CRC_HI:  r_rx_crc <= {i_rx.rx_byte, r_crc_lo};
                    default:    r_cmd    <= r_cmd;
                endcase
            end
        end
    end
endmodule

FILE: sv/cfr_back.sv
// result stage: crc accumulation, status, registered result output
// depends on cfr_pkg, cfr_res_if and crc_frame_receiver_assert.svh
module cfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfr_pkg::t_op        i_op,
    input  cfr_pkg::t_fifo_stat i_stat,
    output logic                o_pop,
    cfr_res_if.source           o_res
);
    import cfr_pkg::*;
    `include "crc_frame_receiver_assert.svh"

    logic             r_valid;
    logic             r_kind;
    logic [7:0]       r_data;
    logic [7:0]       r_index;
    logic [7:0]       r_command;
    logic [LEN_W-1:0] r_length;
    logic [1:0]       r_status;
    logic [15:0]      r_crc;
    logic [15:0]      n_crc;
    logic [1:0]       n_status;
    logic             n_valid;

    assign o_pop = !i_stat.empty && (!r_valid || o_res.ready);

    always_comb begin
        n_valid = r_valid && !o_res.ready;
        if (o_pop) begin
            n_valid = 1'b1;
        end
        n_crc = r_crc;
        if (o_pop) begin
            n_crc = (i_op.kind == KIND_SUMMARY) ? CRC_INIT : crc_update(r_crc, i_op.data);
        end
        if (i_op.bad_end) begin
            n_status = ST_ERR;
        end else if (r_crc != i_op.rx_crc) begin
            n_status = ST_NAK;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_crc   <= CRC_INIT;
        end else begin
            r_valid <= n_valid;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_op.kind;
            if (i_op.kind == KIND_SUMMARY) begin
                r_data    <= '0;
                r_index   <= '0;
                r_command <= i_op.command;
                r_length  <= i_op.length;
                r_status  <= n_status;
            end else begin
                r_data    <= i_op.data;
                r_index   <= i_op.byte_index;
                r_command <= '0;
                r_length  <= '0;
                r_status  <= ST_OK;
            end
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_kind;
    assign o_res.data       = r_data;
    assign o_res.byte_index = r_index;
    assign o_res.command    = r_command;
    assign o_res.length     = r_length;
    assign o_res.status     = r_status;

    `CFR_ASSERT_NEXT(a_crc_rearm, i_clk, i_rst_n, o_pop && i_op.kind == KIND_SUMMARY, r_crc == CRC_INIT, "crc not rearmed after frame end")
    `CFR_ASSERT_NEXT(a_pop_fills, i_clk, i_rst_n, o_pop, r_valid, "popped op left no result")
    `CFR_ASSERT_IMPL(a_status_code, i_clk, i_rst_n, r_valid, r_status == ST_OK || r_status == ST_NAK || r_status == ST_ERR, "status code out of range")
endmodule

FILE: dv/testbench.sv
// self-checking testbench for crc_frame_receiver: flag-delimited frames with crc-16 checks
// depends on cfr_pkg, cfr_rx_if, cfr_res_if and the crc_frame_receiver top level
module testbench;
    import cfr_pkg::*;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          MAX_REPORTS  = 100;

    typedef logic [7:0] t_bytes [$];

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        logic [7:0]       byte_index;
        logic [7:0]       command;
        logic [LEN_W-1:0] length;
        logic [1:0]       status;
    } t_res;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfr_rx_if  rx_if ();
    cfr_res_if res_if ();

    crc_frame_receiver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // register copies
    logic [7:0]       cfg_start = START_FLAG_RST;
    logic [7:0]       cfg_end   = END_FLAG_RST;
    logic [LEN_W-1:0] cfg_max   = MAX_LENGTH_RST;

    // deframer state
    t_phase      ph        = PH_HUNT;
    logic [7:0]  frame_cmd = '0;
    logic [15:0] frame_len = '0;
    logic [15:0] pay_count = '0;
    logic [15:0] run_crc   = CRC_INIT;
    logic [15:0] rx_crc    = '0;

    t_bytes rx_bytes_q;
    t_res   deframed_q [$];

    bit rx_took    = 1'b0;
    bit idle_on    = 1'b1;
    int send_gap   = 0;
    int sink_stall = 0;
    int fail_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_ccitt(input logic [15:0] c, input logic [7:0] d);
        int k;
        c = c ^ {d, 8'h00};
        for (k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic logic [15:0] cap_of();
        return (cfg_max > MAX_PAYLOAD) ? 16'(MAX_PAYLOAD) : 16'(cfg_max);
    endfunction

    function automatic int draw_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        t_res r;
        r = '0;
        case (ph)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    ph        = PH_CMD;
                    run_crc   = CRC_INIT;
                    pay_count = '0;
                end
            end
            PH_CMD: begin
                frame_cmd = b;
                ph        = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                frame_len = {8'h00, b};
                ph        = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                frame_len[15:8] = b;
                if (frame_len > cap_of())
                    frame_len = cap_of();
                pay_count = '0;
                ph = (frame_len == 0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                run_crc      = crc16_ccitt(run_crc, b);
                r.kind       = KIND_PAYLOAD;
                r.data       = b;
                r.byte_index = pay_count[7:0];
                deframed_q.push_back(r);
                pay_count++;
                if (pay_count >= frame_len)
                    ph = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_crc = {8'h00, b};
                ph     = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                rx_crc[15:8] = b;
                ph           = PH_END;
            end
            default: begin
                r.kind    = KIND_SUMMARY;
                r.command = frame_cmd;
                r.length  = frame_len[LEN_W-1:0];
                if (b != cfg_end)
                    r.status = ST_ERR;
                else if (run_crc != rx_crc)
                    r.status = ST_NAK;
                else
                    r.status = ST_OK;
                deframed_q.push_back(r);
                ph = PH_HUNT;
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic match_deframed(input t_res got);
        t_res want;
        if (deframed_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            return;
        end
        want = deframed_q.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", want.kind, got.kind);
        if (got.data !== want.data)
            report_mismatch("data", want.data, got.data);
        if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", want.byte_index, got.byte_index);
        if (got.command !== want.command)
            report_mismatch("command", want.command, got.command);
        if (got.length !== want.length)
            report_mismatch("length", want.length, got.length);
        if (got.status !== want.status)
            report_mismatch("status", want.status, got.status);
    endtask

    // sender and receiver, both driven on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid  <= 1'b0;
            res_if.ready <= 1'b0;
        end else begin
            if (!rx_if.valid || rx_took) begin
                if (send_gap > 0) begin
                    send_gap    <= send_gap - 1;
                    rx_if.valid <= 1'b0;
                end else if (rx_bytes_q.size() != 0) begin
                    rx_if.rx_byte <= rx_bytes_q.pop_front();
                    rx_if.valid   <= 1'b1;
                    send_gap      <= draw_gap();
                end else begin
                    rx_if.valid <= 1'b0;
                end
            end
            if (sink_stall > 0) begin
                sink_stall   <= sink_stall - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                sink_stall   <= draw_gap();
            end
        end
    end

    // transaction monitor on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_took <= 1'b0;
        end else begin
            rx_took <= rx_if.valid && rx_if.ready;
            if (res_if.valid && res_if.ready)
                match_deframed(t_res'({res_if.kind, res_if.data, res_if.byte_index,
                                       res_if.command, res_if.length, res_if.status}));
            if (rx_if.valid && rx_if.ready)
                deframe_byte(rx_if.rx_byte);
        end
    end

    function automatic int add_frame(input logic [7:0] cmd, input logic [15:0] ann,
                                     input t_bytes pl, input bit crc_bad,
                                     input logic [7:0] end_byte, input int keep);
        t_bytes      f;
        logic [15:0] c;
        int          k;
        c = CRC_INIT;
        foreach (pl[j])
            c = crc16_ccitt(c, pl[j]);
        if (crc_bad)
            c = c ^ (16'd1 << $urandom_range(0, 15));
        f = {cfg_start, cmd, ann[7:0], ann[15:8]};
        f = {f, pl, c[7:0], c[15:8], end_byte};
        if (keep < 0 || keep > f.size())
            keep = f.size();
        for (k = 0; k < keep; k++)
            rx_bytes_q.push_back(f[k]);
        return keep;
    endfunction

    task automatic gen_frames(input int budget);
        int          sent;
        int          r;
        int          n;
        int          keep;
        logic [15:0] ann;
        logic [15:0] cap;
        logic [7:0]  endb;
        logic [7:0]  nb;
        t_bytes      pl;
        sent = 0;
        while (sent < budget) begin
            cap = cap_of();
            r   = $urandom_range(0, 99);
            if (r < 55)
                ann = 16'($urandom_range(0, 8));
            else if (r < 85)
                ann = 16'($urandom_range(9, 40));
            else if (r < 90)
                ann = cap;
            else if (r < 95)
                ann = 16'($urandom);
            else
                ann = 16'hFFFF;
            n  = (ann > cap) ? cap : ann;
            pl = {};
            repeat (n) pl.push_back(8'($urandom));
            if ($urandom_range(0, 99) < 10)
                endb = cfg_end ^ 8'($urandom_range(1, 255));
            else
                endb = cfg_end;
            // truncated frame now and then
            keep = -1;
            if ($urandom_range(0, 99) < 5)
                keep = $urandom_range(1, 6 + n);
            sent += add_frame(8'($urandom), ann, pl, $urandom_range(0, 99) < 15, endb, keep);
            // line noise between frames
            if ($urandom_range(0, 99) < 30) begin
                repeat ($urandom_range(1, 4)) begin
                    nb = 8'($urandom);
                    if ($urandom_range(0, 99) < 85)
                        while (nb == cfg_start) nb = 8'($urandom);
                    rx_bytes_q.push_back(nb);
                    sent++;
                end
            end
        end
    endtask

    task automatic drain();
        while (rx_bytes_q.size() != 0 || rx_if.valid || deframed_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_FLAG: cfg_start = val[7:0];
            CFG_END_FLAG:   cfg_end   = val[7:0];
            CFG_MAX_LENGTH: cfg_max   = val;
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [8:0] sf, input logic [8:0] ef,
                             input logic [8:0] ml, input bit idle, input int budget);
        drain();
        write_reg(CFG_START_FLAG, sf);
        write_reg(CFG_END_FLAG, ef);
        write_reg(CFG_MAX_LENGTH, ml);
        idle_on = idle;
        gen_frames(budget);
    endtask

    initial begin
        logic [8:0] v;
        t_bytes     pl;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        res_if.ready  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty frame, start flag inside payload with bad crc, bad end with bad crc
        pl = {};
        void'(add_frame(8'h00, 16'd0, pl, 1'b0, cfg_end, -1));
        pl = {cfg_start, 8'hFF};
        void'(add_frame(8'hFF, 16'd2, pl, 1'b1, cfg_end, -1));
        pl = {8'h00};
        void'(add_frame(8'hA5, 16'd1, pl, 1'b1, cfg_start, -1));
        rx_bytes_q.push_back(8'h55);
        gen_frames(180);

        run_phase(9'h000, 9'h1FF, 9'd0, 1'b1, 200);
        run_phase(9'h0FF, 9'h100, 9'd1, 1'b0, 200);
        v = 9'($urandom_range(0, 255));
        run_phase(v, v, 9'd511, 1'b1, 180);
        run_phase(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                  9'($urandom_range(2, 255)), 1'b1, 220);
        run_phase(9'd126, 9'd125, 9'd256, 1'b0, 220);
        run_phase(9'($urandom_range(0, 255)), 9'($urandom_range(0, 255)),
                  9'($urandom_range(257, 511)), 1'b1, 230);

        drain();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #6000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
